// ----- rtl/iwfet_pkg.sv -----
`timescale 1ns / 1ps
// Package for the wheel frame edge timer: sizes, codes and the result struct.
// No dependencies; used by the frame interface, the top level and the testbench.
package iwfet_pkg;

    localparam int TIME_WIDTH  = 32;
    localparam int CAP_W       = 14;
    localparam int BASE_W      = TIME_WIDTH - CAP_W;
    localparam int OUT_TIME_W  = 32;
    localparam int PAYLOAD_LEN = 14;
    localparam int PHASE_W     = 4;
    localparam int IDX_W       = 4;
    localparam int PADDR_W     = 3;

    localparam logic [PHASE_W-1:0] PHASE_HUNT = 4'd0;
    localparam logic [PHASE_W-1:0] PHASE_LAST = 4'd14;

    localparam logic REG_FRAME_MARKER = 1'b0;
    localparam logic [7:0] MARKER_RESET = 8'h3a;

    typedef struct packed {
        logic signed [15:0]      rate_x;
        logic signed [15:0]      rate_y;
        logic signed [15:0]      rate_z;
        logic signed [15:0]      accel_x;
        logic signed [15:0]      accel_y;
        logic signed [15:0]      accel_z;
        logic [15:0]             wheel_word;
        logic                    edge_seen;
        logic [OUT_TIME_W-1:0]   edge_time;
        logic [OUT_TIME_W-1:0]   edge_period;
    } frame_t;

    function automatic logic [OUT_TIME_W-1:0] out_time(input logic [TIME_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[OUT_TIME_W-1:0];
    endfunction

endpackage

// ----- rtl/iwfet_byte_if.sv -----
`timescale 1ns / 1ps
// Byte channel: valid/ready handshake carrying one received serial byte.
// No dependencies.
interface iwfet_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/iwfet_frame_if.sv -----
`timescale 1ns / 1ps
// Frame result channel: valid/ready handshake carrying one decoded frame.
// Uses iwfet_pkg for the time width.
interface iwfet_frame_if;
    logic                             valid;
    logic                             ready;
    logic signed [15:0]               rate_x;
    logic signed [15:0]               rate_y;
    logic signed [15:0]               rate_z;
    logic signed [15:0]               accel_x;
    logic signed [15:0]               accel_y;
    logic signed [15:0]               accel_z;
    logic [15:0]                      wheel_word;
    logic                             edge_seen;
    logic [iwfet_pkg::OUT_TIME_W-1:0] edge_time;
    logic [iwfet_pkg::OUT_TIME_W-1:0] edge_period;

    modport source (output valid, output rate_x, output rate_y, output rate_z,
                    output accel_x, output accel_y, output accel_z, output wheel_word,
                    output edge_seen, output edge_time, output edge_period,
                    input ready);
    modport sink   (input valid, input rate_x, input rate_y, input rate_z,
                    input accel_x, input accel_y, input accel_z, input wheel_word,
                    input edge_seen, input edge_time, input edge_period,
                    output ready);
endinterface

// ----- rtl/imu_wheel_frame_edge_timer_core.sv -----
`timescale 1ns / 1ps
// Result: the last payload byte sets done_reg, and the result register loads once it is free.
// Throughput: one byte beat per cycle; the byte channel and the payload store
// accept a byte every cycle unless a finished frame waits for a stalled result register.
// Reset: rst_n clears phase, wheel level, time base, last edge time and the
// result valid; frame_marker returns to ':'. The payload store is not cleared.
// Top level of the wheel frame edge timer; uses iwfet_pkg and both channel interfaces.
module imu_wheel_frame_edge_timer_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [iwfet_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    iwfet_byte_if.sink                   rx,
    iwfet_frame_if.source                tx
);
    import iwfet_pkg::*;

    logic [7:0]         marker_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [7:0]         store_reg [PAYLOAD_LEN];
    logic               done_reg;
    logic               level_reg;
    logic [BASE_W-1:0]  base_reg;
    logic [TIME_WIDTH-1:0] last_reg;
    logic               out_valid_reg;
    frame_t             out_reg;
    frame_t             out_next;

    logic               accept;
    logic               advance;
    logic               hunting;
    logic [IDX_W-1:0]   wr_idx;
    logic               reg_sel;

    logic [15:0]           wheel;
    logic [CAP_W-1:0]      cap;
    logic                  level_change;
    logic [BASE_W-1:0]     base_inc;
    logic [BASE_W-1:0]     edge_base;
    logic [TIME_WIDTH-1:0] etime;
    logic [TIME_WIDTH-1:0] eperiod;

    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1];
    assign prdata  = (reg_sel == REG_FRAME_MARKER) ? {24'b0, marker_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg <= MARKER_RESET;
        end
        else if (psel && penable && pwrite && (reg_sel == REG_FRAME_MARKER))
        begin
            marker_reg <= pwdata[7:0];
        end
    end

    // Byte intake: a finished frame waits in the store until the result register frees.
    assign advance  = done_reg && (!out_valid_reg || tx.ready);
    assign rx.ready = !done_reg || advance;
    assign accept   = rx.valid && rx.ready;
    assign hunting  = (phase_reg == PHASE_HUNT) || (phase_reg > PHASE_LAST);
    assign wr_idx   = IDX_W'(phase_reg - PHASE_W'(1));

    always_comb
    begin
        if (hunting)
        begin
            phase_next = (rx.rx_byte == marker_reg) ? PHASE_W'(1) : PHASE_HUNT;
        end
        else if (phase_reg == PHASE_LAST)
        begin
            phase_next = PHASE_HUNT;
        end
        else
        begin
            phase_next = phase_reg + PHASE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_HUNT;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
            end
            done_reg <= (accept && !hunting && (phase_reg == PHASE_LAST)) ||
                        (done_reg && !advance);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !hunting)
        begin
            store_reg[wr_idx] <= rx.rx_byte;
        end
    end

    // Edge timing: the time base has zero low bits, so base plus capture is a concatenation.
    assign wheel        = {store_reg[12], store_reg[13]};
    assign cap          = wheel[CAP_W-1:0];
    assign level_change = wheel[15] != level_reg;
    assign base_inc     = base_reg + BASE_W'(1);
    assign edge_base    = (wheel[14] && !cap[CAP_W-1]) ? base_inc : base_reg;
    assign etime        = {edge_base, cap};
    assign eperiod      = etime - last_reg;

    always_comb
    begin
        out_next.rate_x      = {store_reg[0], store_reg[1]};
        out_next.accel_x     = {store_reg[2], store_reg[3]};
        out_next.rate_y      = {store_reg[4], store_reg[5]};
        out_next.accel_y     = {store_reg[6], store_reg[7]};
        out_next.rate_z      = {store_reg[8], store_reg[9]};
        out_next.accel_z     = {store_reg[10], store_reg[11]};
        out_next.wheel_word  = wheel;
        out_next.edge_seen   = level_change;
        out_next.edge_time   = level_change ? out_time(etime) : '0;
        out_next.edge_period = level_change ? out_time(eperiod) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= 1'b0;
            base_reg      <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                if (wheel[14])
                begin
                    base_reg <= base_inc;
                end
                if (level_change)
                begin
                    last_reg  <= etime;
                    level_reg <= wheel[15];
                end
            end
            else if (tx.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign tx.valid       = out_valid_reg;
    assign tx.rate_x      = out_reg.rate_x;
    assign tx.rate_y      = out_reg.rate_y;
    assign tx.rate_z      = out_reg.rate_z;
    assign tx.accel_x     = out_reg.accel_x;
    assign tx.accel_y     = out_reg.accel_y;
    assign tx.accel_z     = out_reg.accel_z;
    assign tx.wheel_word  = out_reg.wheel_word;
    assign tx.edge_seen   = out_reg.edge_seen;
    assign tx.edge_time   = out_reg.edge_time;
    assign tx.edge_period = out_reg.edge_period;

endmodule

// ----- tb/imu_wheel_frame_edge_timer_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench for imu_wheel_frame_edge_timer_core: framed byte streams with noise,
// random stalls and marker changes, checked frame by frame against a predictor.
// Depends on iwfet_pkg, iwfet_byte_if, iwfet_frame_if and the core RTL.
module imu_wheel_frame_edge_timer_core_tb;
    import iwfet_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_BYTES    = 330;
    localparam int NUM_PHASES     = 4;
    localparam int FRAME_BYTES    = PAYLOAD_LEN + 1;
    localparam int LEVEL_POS      = 15;
    localparam int OVF_POS        = 14;

    localparam logic [PADDR_W-1:0]    MARKER_ADDR = PADDR_W'(4 * REG_FRAME_MARKER);
    localparam logic [PADDR_W-1:0]    SPARE_ADDR  = PADDR_W'(4);
    localparam logic [CAP_W-1:0]      HALF_SPAN   = 14'h2000;
    localparam logic [TIME_WIDTH-1:0] OVF_STEP    = 'h4000;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    iwfet_byte_if  byte_ch();
    iwfet_frame_if frame_ch();

    imu_wheel_frame_edge_timer_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rx      (byte_ch),
        .tx      (frame_ch)
    );

    // predictor state
    logic [7:0]            marker_cfg  = MARKER_RESET;
    logic [PHASE_W-1:0]    frame_pos   = PHASE_HUNT;
    logic [7:0]            payload [PAYLOAD_LEN];
    logic                  wheel_level = 1'b0;
    logic [TIME_WIDTH-1:0] time_base   = '0;
    logic [TIME_WIDTH-1:0] last_edge   = '0;

    frame_t     frames_due [$];
    logic [7:0] byte_q [$];
    frame_t     want;

    int  bytes_queued   = 0;
    int  bytes_sent     = 0;
    int  frames_checked = 0;
    int  edges_seen     = 0;
    int  marker_writes  = 0;
    int  mismatches     = 0;
    int  send_wait      = 0;
    int  take_wait      = 0;
    int  hold_left      = 0;
    int  hold_token     = 0;
    int  hold_seen      = 0;
    int  idle_cycles    = 0;
    bit  steady_send    = 1'b0;
    bit  steady_take    = 1'b0;
    logic offer;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("MISMATCH frame %0d %s: expected 0x%0h, got 0x%0h",
                         frames_checked, name, exp_v, got_v);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic [15:0]           wheel;
        logic [TIME_WIDTH-1:0] cap;
        logic [TIME_WIDTH-1:0] etime;
        logic                  edge_now;
        frame_t                f;
        if (frame_pos == PHASE_HUNT)
            frame_pos = (b == marker_cfg) ? PHASE_HUNT + 1'b1 : PHASE_HUNT;
        else
        begin
            payload[frame_pos - 1'b1] = b;
            if (frame_pos != PHASE_LAST)
                frame_pos = frame_pos + 1'b1;
            else
            begin
                frame_pos = PHASE_HUNT;
                wheel     = {payload[12], payload[13]};
                cap       = TIME_WIDTH'(wheel[CAP_W-1:0]);
                edge_now  = wheel[LEVEL_POS] != wheel_level;
                etime     = '0;
                // place the capture before or after the overflow
                if (wheel[OVF_POS])
                begin
                    if (edge_now && wheel[CAP_W-1:0] >= HALF_SPAN)
                    begin
                        etime     = time_base + cap;
                        time_base = time_base + OVF_STEP;
                    end
                    else
                    begin
                        time_base = time_base + OVF_STEP;
                        if (edge_now)
                            etime = time_base + cap;
                    end
                end
                else if (edge_now)
                    etime = time_base + cap;
                f.rate_x      = {payload[0], payload[1]};
                f.accel_x     = {payload[2], payload[3]};
                f.rate_y      = {payload[4], payload[5]};
                f.accel_y     = {payload[6], payload[7]};
                f.rate_z      = {payload[8], payload[9]};
                f.accel_z     = {payload[10], payload[11]};
                f.wheel_word  = wheel;
                f.edge_seen   = edge_now;
                f.edge_time   = edge_now ? OUT_TIME_W'(etime) : '0;
                f.edge_period = edge_now ? OUT_TIME_W'(etime - last_edge) : '0;
                if (edge_now)
                begin
                    last_edge   = etime;
                    wheel_level = wheel[LEVEL_POS];
                    edges_seen++;
                end
                frames_due.push_back(f);
            end
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        byte_q.push_back(b);
        bytes_queued++;
    endtask

    task automatic queue_frame(input logic [7:0] mark, input logic [95:0] imu,
                               input logic [15:0] wheel);
        push_byte(mark);
        for (int i = 11; i >= 0; i--)
            push_byte(imu[i*8 +: 8]);
        push_byte(wheel[15:8]);
        push_byte(wheel[7:0]);
    endtask

    task automatic wait_idle();
        while (bytes_sent != bytes_queued || frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [31:0] data, output logic [31:0] rd);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        if (wr && addr == MARKER_ADDR)
        begin
            marker_cfg = data[7:0];
            marker_writes++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_ch.valid   <= 1'b0;
            byte_ch.rx_byte <= '0;
            send_wait = 0;
        end
        else
        begin
            offer = byte_ch.valid;
            if (byte_ch.valid && byte_ch.ready)
            begin
                decode_byte(byte_ch.rx_byte);
                bytes_sent++;
                offer = 1'b0;
                send_wait = steady_send ? 0 : $urandom_range(0, 6);
            end
            if (!offer)
            begin
                if (send_wait > 0)
                    send_wait--;
                else if (byte_q.size() > 0)
                begin
                    byte_ch.rx_byte <= byte_q.pop_front();
                    offer = 1'b1;
                end
            end
            byte_ch.valid <= offer;
        end
    end

    // frame monitor and receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_ch.ready <= 1'b0;
            take_wait = 0;
            hold_left = 0;
        end
        else
        begin
            if (frame_ch.valid && frame_ch.ready)
            begin
                if (frames_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("MISMATCH unexpected frame, wheel word 0x%04h",
                                 frame_ch.wheel_word);
                end
                else
                begin
                    want = frames_due.pop_front();
                    check_field("rate_x", want.rate_x, frame_ch.rate_x);
                    check_field("rate_y", want.rate_y, frame_ch.rate_y);
                    check_field("rate_z", want.rate_z, frame_ch.rate_z);
                    check_field("accel_x", want.accel_x, frame_ch.accel_x);
                    check_field("accel_y", want.accel_y, frame_ch.accel_y);
                    check_field("accel_z", want.accel_z, frame_ch.accel_z);
                    check_field("wheel_word", want.wheel_word, frame_ch.wheel_word);
                    check_field("edge_seen", want.edge_seen, frame_ch.edge_seen);
                    check_field("edge_time", want.edge_time, frame_ch.edge_time);
                    check_field("edge_period", want.edge_period, frame_ch.edge_period);
                end
                frames_checked++;
                take_wait = steady_take ? 0 : $urandom_range(0, 6);
            end
            if (hold_seen != hold_token)
            begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                frame_ch.ready <= 1'b0;
            end
            else if (take_wait > 0)
            begin
                take_wait--;
                frame_ch.ready <= 1'b0;
            end
            else
                frame_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((byte_ch.valid && byte_ch.ready) || (frame_ch.valid && frame_ch.ready) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no beat for %0d cycles, %0d frames still due",
                     idle_cycles, frames_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] rd;
        logic [7:0]  mark;
        logic [95:0] imu;
        logic [15:0] wheel;
        logic [13:0] cap;
        int          n;
        int          k;
        int          cut;
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        byte_ch.valid    = 1'b0;
        byte_ch.rx_byte  = '0;
        frame_ch.ready   = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, no edge
        queue_frame(MARKER_RESET, {16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001,
                                   16'hfffe}, 16'h0000);
        push_byte(8'h00);
        push_byte(8'hff);
        push_byte(MARKER_RESET - 1'b1);
        push_byte(MARKER_RESET + 1'b1);
        // rising edge with overflow, capture at half span
        queue_frame(MARKER_RESET, {16'h7fff, 16'h8000, 16'hffff, 16'h0000, 16'hfffe,
                                   16'h0001}, 16'he000);
        // falling edge with overflow, capture just below half span
        queue_frame(MARKER_RESET, {3{32'h5555aaaa}}, 16'h5fff);
        // overflow without edge
        queue_frame(MARKER_RESET, {3{32'haaaa5555}}, 16'h7fff);
        // marker bytes inside payload, edge without overflow
        queue_frame(MARKER_RESET, {12{MARKER_RESET}}, 16'hbfff);
        queue_frame(MARKER_RESET, {6{16'h8000}}, 16'hffff);

        // switch the marker mid-frame
        push_byte(MARKER_RESET);
        repeat (6) push_byte(8'($urandom));
        wait_idle();
        apb_xfer(1'b1, MARKER_ADDR, 32'h0000_0000, rd);
        repeat (6) push_byte(8'($urandom));
        push_byte(8'h00);
        push_byte(8'h00);
        queue_frame(8'h00, {$urandom, $urandom, $urandom}, 16'h8001);
        wait_idle();
        apb_xfer(1'b1, SPARE_ADDR, 32'h0000_00ff, rd);
        apb_xfer(1'b0, MARKER_ADDR, 32'h0, rd);
        check_field("frame_marker readback", 32'(marker_cfg), 32'(rd[7:0]));
        push_byte(MARKER_RESET);
        queue_frame(8'h00, {$urandom, $urandom, $urandom}, 16'h4123);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            case (p)
                0: mark = 8'hff;
                1: mark = 8'($urandom);
                2: mark = MARKER_RESET;
                default: mark = 8'h00;
            endcase
            apb_xfer(1'b1, MARKER_ADDR, 32'(mark), rd);
            apb_xfer(1'b0, MARKER_ADDR, 32'h0, rd);
            check_field("frame_marker readback", 32'(mark), 32'(rd[7:0]));
            steady_send = (p == 1);
            steady_take = (p == 1);
            // hold the receiver off so the core backs up into the byte channel
            if (p == 0)
                hold_token++;
            n = 0;
            while (n < PHASE_BYTES)
            begin
                k = $urandom_range(0, 19);
                if (k < 2)
                    push_byte(8'($urandom));
                else
                begin
                    imu = {$urandom, $urandom, $urandom};
                    if ($urandom_range(0, 7) == 0)
                        imu = {3{32'h80007fff}};
                    case ($urandom_range(0, 7))
                        0: cap = 14'h0000;
                        1: cap = HALF_SPAN - 1'b1;
                        2: cap = HALF_SPAN;
                        3: cap = 14'h3fff;
                        default: cap = 14'($urandom);
                    endcase
                    wheel = {1'($urandom), ($urandom_range(0, 9) < 4), cap};
                    if (k < 4)
                    begin
                        cut = $urandom_range(1, PAYLOAD_LEN - 1);
                        push_byte(mark);
                        repeat (cut) push_byte(8'($urandom));
                        n += cut + 1;
                    end
                    else
                    begin
                        queue_frame(mark, imu, wheel);
                        n += FRAME_BYTES;
                    end
                end
            end
        end

        wait_idle();
        $display("Summary: %0d bytes driven, %0d frames checked, %0d with a wheel edge",
                 bytes_sent, frames_checked, edges_seen);
        $display("Summary: %0d marker writes, receiver hold-off exercised, %0d mismatches",
                 marker_writes, mismatches);
        if (mismatches == 0 && frames_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- imu_wheel_frame_edge_timer_core.f -----
rtl/iwfet_pkg.sv
rtl/iwfet_byte_if.sv
rtl/iwfet_frame_if.sv
rtl/imu_wheel_frame_edge_timer_core.sv
tb/imu_wheel_frame_edge_timer_core_tb.sv
